>>> hdl/tbrt_pkg.sv
// ----------------------------------------------------------------------------
// tbrt_pkg
// Shared types, constants and codes for the token bucket rate table.
// ----------------------------------------------------------------------------
package tbrt_pkg;

	localparam int KINDS     = 4;
	localparam int KW        = 2;
	localparam int SLOTS_DEF = 8;

	localparam int STAMP_W = 48;
	localparam int LEVEL_W = 28;
	localparam int RATE_W  = 16;
	localparam int BURST_W = 8;
	localparam int CFG_W   = 16;
	localparam int CFG_IW  = 3;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 28;
	localparam int MUL_B_W = 20;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// One whole token, in millionths.
	localparam logic [MUL_B_W-1:0] MICRO = 20'd1000000;

	localparam logic [RATE_W-1:0]  GPIO_RATE_RST  = 16'd200;
	localparam logic [RATE_W-1:0]  I2C_RATE_RST   = 16'd100;
	localparam logic [RATE_W-1:0]  HTTP_RATE_RST  = 16'd2;
	localparam logic [RATE_W-1:0]  UART_RATE_RST  = 16'd100;
	localparam logic [BURST_W-1:0] GPIO_BURST_RST = 8'd50;
	localparam logic [BURST_W-1:0] I2C_BURST_RST  = 8'd20;
	localparam logic [BURST_W-1:0] HTTP_BURST_RST = 8'd5;
	localparam logic [BURST_W-1:0] UART_BURST_RST = 8'd20;

	typedef enum logic [1:0] {
		OP_CHECK = 2'd0,
		OP_INIT  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_GPIO_RATE  = 3'd0,
		REG_I2C_RATE   = 3'd1,
		REG_HTTP_RATE  = 3'd2,
		REG_UART_RATE  = 3'd3,
		REG_GPIO_BURST = 3'd4,
		REG_I2C_BURST  = 3'd5,
		REG_HTTP_BURST = 3'd6,
		REG_UART_BURST = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_CAP,
		S_REF,
		S_SUM,
		S_SPEND,
		S_INIT_MUL,
		S_INIT_WR,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [LEVEL_W-1:0] level;
	} entry_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic act_set;
		logic act_clr;
	} store_cmd_t;

endpackage

>>> hdl/tbrt_cfg.sv
// ----------------------------------------------------------------------------
// tbrt_cfg
// Rate and burst registers for the four kinds, written through a plain port.
// ----------------------------------------------------------------------------
module tbrt_cfg (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              cfg_we,
	input  logic [tbrt_pkg::CFG_IW-1:0]                       cfg_index,
	input  logic [tbrt_pkg::CFG_W-1:0]                        cfg_wdata,
	output logic [tbrt_pkg::KINDS-1:0][tbrt_pkg::RATE_W-1:0]  rate,
	output logic [tbrt_pkg::KINDS-1:0][tbrt_pkg::BURST_W-1:0] burst
);

	logic [tbrt_pkg::KINDS-1:0][tbrt_pkg::RATE_W-1:0]  rate_q;
	logic [tbrt_pkg::KINDS-1:0][tbrt_pkg::BURST_W-1:0] burst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q[0]  <= tbrt_pkg::GPIO_RATE_RST;
			rate_q[1]  <= tbrt_pkg::I2C_RATE_RST;
			rate_q[2]  <= tbrt_pkg::HTTP_RATE_RST;
			rate_q[3]  <= tbrt_pkg::UART_RATE_RST;
			burst_q[0] <= tbrt_pkg::GPIO_BURST_RST;
			burst_q[1] <= tbrt_pkg::I2C_BURST_RST;
			burst_q[2] <= tbrt_pkg::HTTP_BURST_RST;
			burst_q[3] <= tbrt_pkg::UART_BURST_RST;
		end else if (cfg_we) begin
			case (tbrt_pkg::cfg_reg_t'(cfg_index))
				tbrt_pkg::REG_GPIO_RATE:  rate_q[0]  <= cfg_wdata;
				tbrt_pkg::REG_I2C_RATE:   rate_q[1]  <= cfg_wdata;
				tbrt_pkg::REG_HTTP_RATE:  rate_q[2]  <= cfg_wdata;
				tbrt_pkg::REG_UART_RATE:  rate_q[3]  <= cfg_wdata;
				tbrt_pkg::REG_GPIO_BURST: burst_q[0] <= cfg_wdata[tbrt_pkg::BURST_W-1:0];
				tbrt_pkg::REG_I2C_BURST:  burst_q[1] <= cfg_wdata[tbrt_pkg::BURST_W-1:0];
				tbrt_pkg::REG_HTTP_BURST: burst_q[2] <= cfg_wdata[tbrt_pkg::BURST_W-1:0];
				tbrt_pkg::REG_UART_BURST: burst_q[3] <= cfg_wdata[tbrt_pkg::BURST_W-1:0];
				default: ;
			endcase
		end
	end

	assign rate  = rate_q;
	assign burst = burst_q;

endmodule

>>> hdl/tbrt_mul.sv
// ----------------------------------------------------------------------------
// tbrt_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module tbrt_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tbrt_pkg::MUL_A_W-1:0]  a,
	input  logic [tbrt_pkg::MUL_B_W-1:0]  b,
	output logic [tbrt_pkg::PROD_W-1:0]   prod
);

	logic [tbrt_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= tbrt_pkg::PROD_W'(a) * tbrt_pkg::PROD_W'(b);
		end
	end

	assign prod = prod_q;

endmodule

>>> hdl/tbrt_store.sv
// ----------------------------------------------------------------------------
// tbrt_store
// Bucket memory (stamp and level per bucket) and per-slot active flags.
// ----------------------------------------------------------------------------
module tbrt_store #(
	parameter int SLOTS = tbrt_pkg::SLOTS_DEF,
	parameter int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	parameter int AW    = SW + tbrt_pkg::KW
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tbrt_pkg::store_cmd_t   cmd,
	input  logic [AW-1:0]          rd_addr,
	output tbrt_pkg::entry_t       rd_data,
	input  logic [AW-1:0]          wr_addr,
	input  tbrt_pkg::entry_t       wr_data,
	input  logic [SW-1:0]          act_slot,
	output logic                   act
);

	localparam int ENTRIES = SLOTS * tbrt_pkg::KINDS;

	tbrt_pkg::entry_t mem [ENTRIES];
	tbrt_pkg::entry_t rd_data_q;
	logic [SLOTS-1:0] active_q;

	// Read entries are only used once init has written the whole slot, so the
	// memory itself needs no clearing.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cmd.act_set) begin
			active_q[act_slot] <= 1'b1;
		end else if (cmd.act_clr) begin
			active_q[act_slot] <= 1'b0;
		end
	end

	assign rd_data = rd_data_q;
	assign act     = active_q[act_slot];

endmodule

>>> hdl/token_bucket_rate_table.sv
// ----------------------------------------------------------------------------
// token_bucket_rate_table
// Table of token buckets, one per client slot and kind, with check, init
// and clear operations run by a small sequencer around one multiplier.
// ----------------------------------------------------------------------------
// A check runs decode, capacity, refill, sum and spend; an init runs a
// multiply and a write for each kind in turn; a clear or a refused item
// only decodes. A new item is taken only in idle, after the result has
// moved to the output register; the multiplier and write port are shared.
// Reset clears all active flags, restores the rate and burst registers and
// leaves the sequencer idle; the bucket memory is not cleared.
// ----------------------------------------------------------------------------
module token_bucket_rate_table #(
	parameter int SLOTS = tbrt_pkg::SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Request channel.
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        op,
	input  logic [7:0]                        slot,
	input  logic [2:0]                        kind,
	input  logic [tbrt_pkg::STAMP_W-1:0]      now_us,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              granted,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [tbrt_pkg::CFG_IW-1:0]       cfg_index,
	input  logic [tbrt_pkg::CFG_W-1:0]        cfg_wdata
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KW = tbrt_pkg::KW;
	localparam int AW = SW + KW;
	localparam int LW = tbrt_pkg::LEVEL_W;
	localparam int SUM_W = 45;

	// Configuration registers.
	logic [tbrt_pkg::KINDS-1:0][tbrt_pkg::RATE_W-1:0]  rate_all;
	logic [tbrt_pkg::KINDS-1:0][tbrt_pkg::BURST_W-1:0] burst_all;

	tbrt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rate      (rate_all),
		.burst     (burst_all)
	);

	// Sequencer state and the item being worked on.
	tbrt_pkg::state_t state_q, state_d;
	tbrt_pkg::op_t    op_q;
	logic [7:0]       slot_q;
	logic [2:0]       kind_q;
	logic [tbrt_pkg::STAMP_W-1:0] now_q;
	logic [KW-1:0]    k_q;

	// Working registers of a check.
	logic [LW-1:0]    el_q;
	logic             sat_q;
	logic [LW-1:0]    cap_q;
	logic [LW-1:0]    lvl_q;
	logic             grant_q;

	// Output register.
	logic             out_valid_q;
	logic             granted_q;

	// Shared multiplier.
	logic                          mul_en;
	logic [tbrt_pkg::MUL_A_W-1:0]  mul_a;
	logic [tbrt_pkg::MUL_B_W-1:0]  mul_b;
	logic [tbrt_pkg::PROD_W-1:0]   prod;

	tbrt_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Bucket store.
	tbrt_pkg::store_cmd_t cmd;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	tbrt_pkg::entry_t     rd_data;
	tbrt_pkg::entry_t     wr_data;
	logic                 act;

	tbrt_store #(
		.SLOTS (SLOTS),
		.SW    (SW),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.act_slot (slot_q[SW-1:0]),
		.act      (act)
	);

	logic                         accept;
	logic                         slot_ok;
	logic                         kind_ok;
	logic [tbrt_pkg::RATE_W-1:0]  rate_sel;
	logic [tbrt_pkg::BURST_W-1:0] burst_sel;
	logic [tbrt_pkg::STAMP_W-1:0] elapsed;
	logic [SUM_W-1:0]             sum;
	logic [LW-1:0]                lvl_capped;
	logic                         can_spend;
	logic [LW-1:0]                lvl_spent;
	logic                         out_free;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == tbrt_pkg::S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// Slot must be below the slot count; a kind above three is refused.
	assign slot_ok   = (9'(slot_q) < 9'(SLOTS));
	assign kind_ok   = !kind_q[2];
	assign rate_sel  = rate_all[kind_q[KW-1:0]];
	assign burst_sel = burst_all[kind_q[KW-1:0]];

	// The bucket is read as the item is accepted, so its entry is ready
	// when the sequencer decodes the operation.
	assign rd_addr = {slot[SW-1:0], kind[KW-1:0]};

	// Time running backwards counts as no time at all.
	assign elapsed = (now_q > rd_data.stamp) ? (now_q - rd_data.stamp) : '0;

	// Refill: a long gap with a nonzero rate fills the bucket outright;
	// otherwise the product of elapsed time and rate is added. A zero rate
	// gives a zero product, so the old level just passes through.
	assign sum = (sat_q && (rate_sel != '0)) ? SUM_W'(cap_q)
		: (SUM_W'(rd_data.level) + prod[SUM_W-1:0]);
	assign lvl_capped = (sum > SUM_W'(cap_q)) ? cap_q : sum[LW-1:0];

	assign can_spend = (lvl_q >= LW'(tbrt_pkg::MICRO));
	assign lvl_spent = can_spend ? (lvl_q - LW'(tbrt_pkg::MICRO)) : lvl_q;

	// Next state, multiplier operands and store commands.
	always_comb begin
		state_d     = state_q;
		mul_en      = 1'b0;
		mul_a       = '0;
		mul_b       = '0;
		cmd         = '0;
		cmd.rd_en   = accept;
		wr_addr     = {slot_q[SW-1:0], kind_q[KW-1:0]};
		wr_data     = '0;
		case (state_q)
			tbrt_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = tbrt_pkg::S_DEC;
				end
			end
			tbrt_pkg::S_DEC: begin
				state_d = tbrt_pkg::S_FIN;
				if (slot_ok) begin
					case (op_q)
						tbrt_pkg::OP_CHECK: begin
							if (kind_ok && act) begin
								state_d = tbrt_pkg::S_CAP;
							end
						end
						tbrt_pkg::OP_INIT:  state_d = tbrt_pkg::S_INIT_MUL;
						tbrt_pkg::OP_CLEAR: cmd.act_clr = 1'b1;
						tbrt_pkg::OP_NONE:  ;
						default: ;
					endcase
				end
			end
			tbrt_pkg::S_CAP: begin
				// Capacity in millionths.
				mul_en  = 1'b1;
				mul_a   = tbrt_pkg::MUL_A_W'(burst_sel);
				mul_b   = tbrt_pkg::MICRO;
				state_d = tbrt_pkg::S_REF;
			end
			tbrt_pkg::S_REF: begin
				// Refill amount: elapsed microseconds times tokens per second.
				mul_en  = 1'b1;
				mul_a   = el_q;
				mul_b   = tbrt_pkg::MUL_B_W'(rate_sel);
				state_d = tbrt_pkg::S_SUM;
			end
			tbrt_pkg::S_SUM: begin
				state_d = tbrt_pkg::S_SPEND;
			end
			tbrt_pkg::S_SPEND: begin
				cmd.wr_en     = 1'b1;
				wr_data.stamp = now_q;
				wr_data.level = lvl_spent;
				state_d       = tbrt_pkg::S_FIN;
			end
			tbrt_pkg::S_INIT_MUL: begin
				mul_en  = 1'b1;
				mul_a   = tbrt_pkg::MUL_A_W'(burst_all[k_q]);
				mul_b   = tbrt_pkg::MICRO;
				state_d = tbrt_pkg::S_INIT_WR;
			end
			tbrt_pkg::S_INIT_WR: begin
				cmd.wr_en     = 1'b1;
				wr_addr       = {slot_q[SW-1:0], k_q};
				wr_data.stamp = now_q;
				wr_data.level = prod[LW-1:0];
				if (k_q == KW'(tbrt_pkg::KINDS - 1)) begin
					cmd.act_set = 1'b1;
					state_d     = tbrt_pkg::S_FIN;
				end else begin
					state_d = tbrt_pkg::S_INIT_MUL;
				end
			end
			tbrt_pkg::S_FIN: begin
				if (out_free) begin
					state_d = tbrt_pkg::S_IDLE;
				end
			end
			default: state_d = tbrt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbrt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item registers and the working registers of the sequence.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= tbrt_pkg::op_t'(op);
			slot_q <= slot;
			kind_q <= kind;
			now_q  <= now_us;
		end
		case (state_q)
			tbrt_pkg::S_DEC: begin
				grant_q <= 1'b0;
				k_q     <= '0;
			end
			tbrt_pkg::S_CAP: begin
				sat_q <= |elapsed[tbrt_pkg::STAMP_W-1:LW];
				el_q  <= elapsed[LW-1:0];
			end
			tbrt_pkg::S_REF: begin
				cap_q <= prod[LW-1:0];
			end
			tbrt_pkg::S_SUM: begin
				lvl_q <= lvl_capped;
			end
			tbrt_pkg::S_SPEND: begin
				grant_q <= can_spend;
			end
			tbrt_pkg::S_INIT_WR: begin
				k_q <= k_q + KW'(1);
			end
			default: ;
		endcase
	end

	// Output register: the result waits here while the next item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tbrt_pkg::S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tbrt_pkg::S_FIN && out_free) begin
			granted_q <= grant_q;
		end
	end

	assign out_valid = out_valid_q;
	assign granted   = granted_q;

	// An accepted item always goes to decode next.
	a_accept_dec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == tbrt_pkg::S_DEC))
		else $error("accepted item did not enter decode");

	// The bucket memory is never written while the sequencer is idle.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tbrt_pkg::S_IDLE) |-> !cmd.wr_en)
		else $error("bucket write while idle");

	// The refilled level never exceeds the capacity of the bucket.
	a_level_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tbrt_pkg::S_SPEND) |-> (lvl_q <= cap_q))
		else $error("refilled level above capacity");

	// Init finishes after writing the last kind of the slot.
	a_init_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tbrt_pkg::S_INIT_WR && k_q == KW'(tbrt_pkg::KINDS - 1))
		|=> (state_q == tbrt_pkg::S_FIN))
		else $error("init did not finish after last kind");

endmodule

>>> tb/sv/tbrt_grant_checker.sv
// ----------------------------------------------------------------------------
// tbrt_grant_checker
// Watches the request, result and configuration ports of the token bucket
// rate table. It predicts the granted bit of every accepted request and
// compares it with the result items as they are accepted.
// ----------------------------------------------------------------------------
module tbrt_grant_checker #(
	parameter int SLOTS = tbrt_pkg::SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [1:0]                   op,
	input  logic [7:0]                   slot,
	input  logic [2:0]                   kind,
	input  logic [tbrt_pkg::STAMP_W-1:0] now_us,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         granted,
	input  logic                         cfg_we,
	input  logic [tbrt_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [tbrt_pkg::CFG_W-1:0]   cfg_wdata,
	output int                           pending,
	output int                           errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          KINDS     = tbrt_pkg::KINDS;
	localparam int          BUCKETS   = SLOTS * KINDS;
	localparam logic [63:0] ONE_TOKEN = 64'd1000000;
	// Elapsed times at or beyond this refill to the cap when the rate is nonzero.
	localparam logic [63:0] SAT_US    = 64'd1 << 28;

	logic [tbrt_pkg::STAMP_W-1:0] stamp_mem [BUCKETS];
	logic [tbrt_pkg::LEVEL_W-1:0] level_mem [BUCKETS];
	logic                         live_mem  [BUCKETS];
	logic [tbrt_pkg::RATE_W-1:0]  rate_reg  [KINDS];
	logic [tbrt_pkg::BURST_W-1:0] burst_reg [KINDS];

	logic grant_q [$];
	logic want_g;

	// Applies one request to the shadow bucket table and returns its grant.
	function automatic logic predict_grant(logic [1:0] op_i, logic [7:0] slot_i,
			logic [2:0] kind_i, logic [tbrt_pkg::STAMP_W-1:0] now_i);
		int          e;
		logic [63:0] cap;
		logic [63:0] lvl;
		logic [63:0] elapsed;
		logic        g;
		g = 1'b0;
		if (slot_i >= SLOTS)
			return 1'b0;
		case (op_i)
			tbrt_pkg::OP_INIT: begin
				for (int k = 0; k < KINDS; k++) begin
					e = int'(slot_i) * KINDS + k;
					stamp_mem[e] = now_i;
					level_mem[e] = tbrt_pkg::LEVEL_W'(64'(burst_reg[k]) * ONE_TOKEN);
					live_mem[e]  = 1'b1;
				end
			end
			tbrt_pkg::OP_CLEAR: begin
				for (int k = 0; k < KINDS; k++) begin
					e = int'(slot_i) * KINDS + k;
					stamp_mem[e] = '0;
					level_mem[e] = '0;
					live_mem[e]  = 1'b0;
				end
			end
			tbrt_pkg::OP_CHECK: begin
				if (kind_i < KINDS) begin
					e = int'(slot_i) * KINDS + int'(kind_i);
					if (live_mem[e]) begin
						cap = 64'(burst_reg[kind_i[1:0]]) * ONE_TOKEN;
						elapsed = (now_i > stamp_mem[e]) ? 64'(now_i - stamp_mem[e]) : 64'd0;
						stamp_mem[e] = now_i;
						lvl = 64'(level_mem[e]);
						if (rate_reg[kind_i[1:0]] != '0) begin
							if (elapsed >= SAT_US)
								lvl = cap;
							else
								lvl = lvl + elapsed * 64'(rate_reg[kind_i[1:0]]);
						end
						if (lvl > cap)
							lvl = cap;
						if (lvl >= ONE_TOKEN) begin
							lvl = lvl - ONE_TOKEN;
							g = 1'b1;
						end
						level_mem[e] = tbrt_pkg::LEVEL_W'(lvl);
					end
				end
			end
			default: ;
		endcase
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < BUCKETS; e++)
				live_mem[e] = 1'b0;
			rate_reg[0]  = tbrt_pkg::GPIO_RATE_RST;
			rate_reg[1]  = tbrt_pkg::I2C_RATE_RST;
			rate_reg[2]  = tbrt_pkg::HTTP_RATE_RST;
			rate_reg[3]  = tbrt_pkg::UART_RATE_RST;
			burst_reg[0] = tbrt_pkg::GPIO_BURST_RST;
			burst_reg[1] = tbrt_pkg::I2C_BURST_RST;
			burst_reg[2] = tbrt_pkg::HTTP_BURST_RST;
			burst_reg[3] = tbrt_pkg::UART_BURST_RST;
			grant_q.delete();
			pending = 0;
			errors  = 0;
		end else begin
			// Results are retired before new requests are queued, so a result
			// can never be matched against a request accepted on the same edge.
			if (out_valid && out_ready) begin
				if (grant_q.size() == 0) begin
					$error("granted: result item with nothing expected, actual %0d", granted);
					errors++;
				end else begin
					want_g = grant_q.pop_front();
					if (granted !== want_g) begin
						$error("granted mismatch: expected %0d, actual %0d", want_g, granted);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				grant_q.push_back(predict_grant(op, slot, kind, now_us));
			if (cfg_we) begin
				if (cfg_index <= tbrt_pkg::REG_UART_RATE)
					rate_reg[cfg_index[1:0]] = cfg_wdata[tbrt_pkg::RATE_W-1:0];
				else
					burst_reg[cfg_index[1:0]] = cfg_wdata[tbrt_pkg::BURST_W-1:0];
			end
			pending = grant_q.size();
		end
	end

endmodule

>>> tb/sv/token_bucket_rate_table_tb.sv
// ----------------------------------------------------------------------------
// token_bucket_rate_table_tb
// Drives the token bucket rate table with a directed set of requests and then
// with random phases under several rate and burst settings, while a checker
// beside the block predicts and compares every granted bit.
// ----------------------------------------------------------------------------
module token_bucket_rate_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          NSLOTS    = tbrt_pkg::SLOTS_DEF;
	localparam int          KINDS     = tbrt_pkg::KINDS;
	localparam int          LIMIT     = 400000;
	localparam int          PHASES    = 8;
	localparam int          PER_PHASE = 140;
	localparam int          HOLD_LEN  = 300;
	localparam logic [47:0] T_MAX     = '1;
	localparam logic [47:0] SAT_US    = 48'd1 << 28;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [1:0]                   op;
	logic [7:0]                   slot;
	logic [2:0]                   kind;
	logic [tbrt_pkg::STAMP_W-1:0] now_us;
	logic                         out_valid;
	logic                         out_ready;
	logic                         granted;
	logic                         cfg_we;
	logic [tbrt_pkg::CFG_IW-1:0]  cfg_index;
	logic [tbrt_pkg::CFG_W-1:0]   cfg_wdata;

	int chk_pending;
	int chk_errors;

	// Time base that the random requests mostly move forward.
	logic [47:0] tcur;
	// Items left in the current burst of the sender.
	int          burst_left;
	// Set by the stimulus to ask the receiver for one long hold-off.
	logic        hold_go;
	int          cycles;

	token_bucket_rate_table #(
		.SLOTS(NSLOTS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.slot     (slot),
		.kind     (kind),
		.now_us   (now_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.granted  (granted),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	tbrt_grant_checker #(
		.SLOTS(NSLOTS)
	) grant_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.slot     (slot),
		.kind     (kind),
		.now_us   (now_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.granted  (granted),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pending  (chk_pending),
		.errors   (chk_errors)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Offers one item at the current falling edge and holds it until the
	// block takes it. Returns at the falling edge after acceptance, with
	// valid still high so that a following item can go out back to back.
	task automatic send_item(input logic [1:0] o, input logic [7:0] s,
			input logic [2:0] k, input logic [47:0] t);
		logic done;
		op       = o;
		slot     = s;
		kind     = k;
		now_us   = t;
		in_valid = 1'b1;
		done     = 1'b0;
		while (!done) begin
			@(posedge clk);
			done = in_ready;
			@(negedge clk);
		end
	endtask

	// Bursts of random length separated by random gaps. Now and then a long
	// burst gives a stretch with no idling at all on the request side.
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	// Stops sending and waits for every outstanding result. The extra cycles
	// let the sequencer settle back to idle before any register write.
	task automatic drain();
		in_valid = 1'b0;
		while (chk_pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input tbrt_pkg::cfg_reg_t idx,
			input logic [tbrt_pkg::CFG_W-1:0] d);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = d;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Mostly checks on live slots with time moving forward, mixed with inits,
	// clears, refused slots and kinds, backward time and very long gaps.
	task automatic run_random(input int count);
		int          r;
		logic [1:0]  o;
		logic [7:0]  s;
		logic [2:0]  k;
		logic [47:0] t;
		logic [63:0] rnd64;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 78)
				o = tbrt_pkg::OP_CHECK;
			else if (r < 89)
				o = tbrt_pkg::OP_INIT;
			else if (r < 97)
				o = tbrt_pkg::OP_CLEAR;
			else
				o = tbrt_pkg::OP_NONE;
			s = ($urandom_range(0, 99) < 92) ? 8'($urandom_range(0, NSLOTS - 1))
				: 8'($urandom_range(NSLOTS, 255));
			k = ($urandom_range(0, 99) < 92) ? 3'($urandom_range(0, KINDS - 1))
				: 3'($urandom_range(KINDS, 7));
			r = $urandom_range(0, 99);
			if (r < 80) begin
				tcur = tcur + 48'($urandom_range(0, 12000));
				t = tcur;
			end else if (r < 87) begin
				t = tcur - 48'($urandom_range(1, 5000));
			end else if (r < 92) begin
				tcur = tcur + SAT_US - 48'd1 + 48'($urandom_range(0, 2));
				t = tcur;
			end else if (r < 95) begin
				rnd64 = {$urandom(), $urandom()};
				tcur = rnd64[47:0];
				t = tcur;
			end else begin
				t = tcur;
			end
			pace();
			send_item(o, s, k, t);
		end
	endtask

	// The receiver runs on a pattern of its own: it switches between always
	// ready, coin-flip ready, a periodic pattern and a mostly stalled mode.
	// Once asked, it holds off for a long stretch so that the block fills up
	// and has to push back on the request side.
	initial begin : receiver
		int mode;
		int mode_left;
		int tick;
		int held;
		logic hold_done;
		mode      = 0;
		mode_left = 0;
		tick      = 0;
		held      = 0;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (hold_go && !hold_done) begin
				out_ready = 1'b0;
				held++;
				if (held >= HOLD_LEN)
					hold_done = 1'b1;
			end else begin
				case (mode)
					0: out_ready = 1'b1;
					1: out_ready = $urandom_range(0, 1);
					2: out_ready = (tick % 5) != 0;
					default: out_ready = ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Watchdog: a run that hangs is a failing run.
	initial begin : watchdog
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		logic [tbrt_pkg::RATE_W-1:0] rv;
		logic [tbrt_pkg::CFG_W-1:0]  bv;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		op         = tbrt_pkg::OP_CHECK;
		slot       = '0;
		kind       = '0;
		now_us     = '0;
		cfg_we     = 1'b0;
		cfg_index  = tbrt_pkg::REG_GPIO_RATE;
		cfg_wdata  = '0;
		tcur       = '0;
		burst_left = 0;
		hold_go    = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed part, run on the reset rates and bursts.
		// A check on a bucket that was never set up is refused.
		send_item(tbrt_pkg::OP_CHECK, 8'd0, 3'd0, 48'd0);
		send_item(tbrt_pkg::OP_INIT, 8'd0, 3'd0, 48'd1000);
		send_item(tbrt_pkg::OP_CHECK, 8'd0, 3'd0, 48'd1000);
		// Kinds beyond the table are refused.
		send_item(tbrt_pkg::OP_CHECK, 8'd0, 3'd4, 48'd1000);
		send_item(tbrt_pkg::OP_CHECK, 8'd0, 3'd7, 48'd1000);
		// Empty the small bucket with no time passing: five grants, then no.
		repeat (6) send_item(tbrt_pkg::OP_CHECK, 8'd0, 3'd2, 48'd1000);
		// Refill lands two millionths short of a token, then exactly on one.
		send_item(tbrt_pkg::OP_CHECK, 8'd0, 3'd2, 48'd1000 + 48'd499999);
		send_item(tbrt_pkg::OP_CHECK, 8'd0, 3'd2, 48'd1000 + 48'd500000);
		// Elapsed time just below and at the saturation point.
		send_item(tbrt_pkg::OP_CHECK, 8'd0, 3'd1, 48'd1000 + SAT_US - 48'd1);
		send_item(tbrt_pkg::OP_CHECK, 8'd0, 3'd3, 48'd1000 + SAT_US);
		// Time going backwards counts as zero elapsed.
		send_item(tbrt_pkg::OP_CHECK, 8'd0, 3'd3, 48'd500);
		send_item(tbrt_pkg::OP_INIT, 8'(NSLOTS - 1), 3'd0, T_MAX);
		send_item(tbrt_pkg::OP_CHECK, 8'(NSLOTS - 1), 3'd3, 48'd0);
		// Slots beyond the table are refused for every operation.
		send_item(tbrt_pkg::OP_INIT, 8'(NSLOTS), 3'd0, 48'd5);
		send_item(tbrt_pkg::OP_CHECK, 8'd255, 3'd0, 48'd5);
		send_item(tbrt_pkg::OP_CLEAR, 8'd255, 3'd0, 48'd5);
		// The undefined operation does nothing.
		send_item(tbrt_pkg::OP_NONE, 8'd0, 3'd0, 48'd2000);
		// A cleared slot refuses every check; the last slot, not cleared, still grants.
		send_item(tbrt_pkg::OP_CLEAR, 8'd0, 3'd0, T_MAX);
		send_item(tbrt_pkg::OP_CHECK, 8'd0, 3'd0, T_MAX);
		send_item(tbrt_pkg::OP_CHECK, 8'(NSLOTS - 1), 3'd0, T_MAX);

		// Random phases. Phase zero zeroes every register, phase one sets
		// every rate and burst to its top value with all data bits high,
		// phase two uses the smallest useful values, the rest are random.
		for (int p = 0; p < PHASES; p++) begin
			drain();
			for (int i = 0; i < KINDS; i++) begin
				case (p)
					0: begin
						rv = '0;
						bv = '0;
					end
					1: begin
						rv = '1;
						bv = '1;
					end
					2: begin
						rv = 16'd1;
						bv = 16'd1;
					end
					default: begin
						rv = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
							: 16'($urandom_range(0, 40));
						bv = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
							: 16'($urandom_range(0, 6));
					end
				endcase
				write_reg(tbrt_pkg::cfg_reg_t'(i), 16'(rv));
				write_reg(tbrt_pkg::cfg_reg_t'(i + KINDS), bv);
			end
			case (p % 3)
				0: tcur = '0;
				1: tcur = T_MAX - 48'd5000000;
				default: tcur = 48'({$urandom(), $urandom()});
			endcase
			// Bring every slot up first so that most checks go deep.
			for (int s = 0; s < NSLOTS; s++) begin
				pace();
				tcur = tcur + 48'($urandom_range(0, 50));
				send_item(tbrt_pkg::OP_INIT, 8'(s), 3'($urandom_range(0, 7)), tcur);
			end
			if (p == 3)
				hold_go = 1'b1;
			run_random(PER_PHASE);
		end

		// Let the last results come out, then a short tail for stray items.
		in_valid = 1'b0;
		while (chk_pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (chk_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
hdl/tbrt_pkg.sv
hdl/tbrt_cfg.sv
hdl/tbrt_mul.sv
hdl/tbrt_store.sv
hdl/token_bucket_rate_table.sv
tb/sv/tbrt_grant_checker.sv
tb/sv/token_bucket_rate_table_tb.sv
